// File: rtl/lctp_pkg.sv
package lctp_pkg;

  localparam int FREQ_W        = 31;
  localparam int FREQ_UNIT     = 100;
  localparam int JOIN_LIST_END = 8;
  localparam int RAND_W        = 32;

  localparam logic [1:0] KIND_INIT = 2'd0;
  localparam logic [1:0] KIND_LOAD = 2'd1;
  localparam logic [1:0] KIND_PICK = 2'd2;

  localparam logic [1:0] CFG_FREQ_A = 2'd0;
  localparam logic [1:0] CFG_FREQ_B = 2'd1;
  localparam logic [1:0] CFG_FREQ_C = 2'd2;

  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  entry_slot;
    logic [23:0] entry_value;
    logic [31:0] random_value;
  } item_t;

  typedef struct packed {
    logic [30:0] frequency;
    logic        none_available;
  } result_t;

  typedef struct packed {
    logic capture;
    logic clear_used;
    logic init_step;
    logic load_write;
    logic count_step;
    logic set_none;
    logic div_start;
    logic div_step;
    logic sel_step;
    logic grab;
  } lctp_cmd_t;

  typedef struct packed {
    logic def_last;
    logic scan_last;
    logic count_zero;
    logic div_last;
    logic hit;
  } lctp_sts_t;

endpackage

// File: rtl/lctp_dp.sv
module lctp_dp #(
  parameter int TABLE_SLOTS   = 16,
  parameter int DEFAULT_SLOTS = 3
) (
  input  logic              clk,
  input  logic              rst,
  input  lctp_pkg::lctp_cmd_t cmd,
  input  lctp_pkg::item_t   item,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [30:0]       cfg_data,
  output lctp_pkg::lctp_sts_t sts,
  output lctp_pkg::result_t result
);
  import lctp_pkg::*;

  localparam int IW = $clog2(TABLE_SLOTS);
  localparam int CW = $clog2(TABLE_SLOTS + 1);

  logic [FREQ_W-1:0] default_freq_a;
  logic [FREQ_W-1:0] default_freq_b;
  logic [FREQ_W-1:0] default_freq_c;

  logic [FREQ_W-1:0] mem [TABLE_SLOTS];
  logic [TABLE_SLOTS-1:0] used;

  item_t             item_q;
  logic [IW-1:0]     idx;
  logic [CW-1:0]     count;
  logic [CW-1:0]     rem;
  logic [RAND_W-1:0] dvd;
  logic [4:0]        div_cnt;
  logic [FREQ_W-1:0] rd_q;
  logic [FREQ_W-1:0] res_freq;
  logic              res_none;

  logic [FREQ_W-1:0] def_val;
  logic [FREQ_W-1:0] prod;
  logic [3:0]        jslot;
  logic              in_range;
  logic [CW:0]       trial;
  logic [CW-1:0]     rem_next;

  always_comb begin
    unique case (idx)
      IW'(0):  def_val = (DEFAULT_SLOTS > 0) ? default_freq_a : '0;
      IW'(1):  def_val = (DEFAULT_SLOTS > 1) ? default_freq_b : '0;
      IW'(2):  def_val = (DEFAULT_SLOTS > 2) ? default_freq_c : '0;
      default: def_val = '0;
    endcase
  end

  assign prod     = FREQ_W'(item_q.entry_value) * FREQ_W'(FREQ_UNIT);
  assign jslot    = 4'(DEFAULT_SLOTS) + {1'b0, item_q.entry_slot};
  assign in_range = (int'(jslot) < JOIN_LIST_END) && (int'(jslot) < TABLE_SLOTS);

  // restoring division, one dividend bit a cycle
  assign trial = {rem, dvd[RAND_W-1]};
  always_comb begin
    if (trial >= {1'b0, count}) begin
      rem_next = CW'(trial - {1'b0, count});
    end else begin
      rem_next = trial[CW-1:0];
    end
  end

  assign sts.def_last   = (idx == IW'(DEFAULT_SLOTS - 1));
  assign sts.scan_last  = (idx == IW'(TABLE_SLOTS - 1));
  assign sts.count_zero = (count == '0);
  assign sts.div_last   = (div_cnt == 5'd31);
  assign sts.hit        = used[idx] && (rem == '0);

  assign result.frequency      = res_freq;
  assign result.none_available = res_none;

  always_ff @(posedge clk) begin
    if (rst) begin
      default_freq_a <= 31'd868100000;
      default_freq_b <= 31'd868300000;
      default_freq_c <= 31'd868500000;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FREQ_A: default_freq_a <= cfg_data;
        CFG_FREQ_B: default_freq_b <= cfg_data;
        CFG_FREQ_C: default_freq_c <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
    end else if (cmd.clear_used) begin
      used <= '0;
    end else if (cmd.init_step) begin
      used[idx] <= (def_val != '0);
    end else if (cmd.load_write && in_range) begin
      used[IW'(jslot)] <= (prod != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.init_step) begin
      mem[idx] <= def_val;
    end else if (cmd.load_write && in_range) begin
      mem[IW'(jslot)] <= prod;
    end
    if (cmd.sel_step) begin
      rd_q <= mem[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_q <= item;
    end
    if (cmd.capture || cmd.div_start) begin
      idx <= '0;
    end else if (cmd.init_step || cmd.count_step || cmd.sel_step) begin
      idx <= idx + IW'(1);
    end
    if (cmd.capture) begin
      count <= '0;
    end else if (cmd.count_step && used[idx]) begin
      count <= count + CW'(1);
    end
    if (cmd.div_start) begin
      rem     <= '0;
      dvd     <= item_q.random_value;
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      rem     <= rem_next;
      dvd     <= {dvd[RAND_W-2:0], 1'b0};
      div_cnt <= div_cnt + 5'd1;
    end else if (cmd.sel_step && used[idx] && (rem != '0)) begin
      rem <= rem - CW'(1);
    end
    if (cmd.capture) begin
      res_freq <= '0;
      res_none <= 1'b0;
    end else if (cmd.load_write) begin
      res_freq <= in_range ? prod : '0;
    end else if (cmd.set_none) begin
      res_none <= 1'b1;
    end else if (cmd.grab) begin
      res_freq <= rd_q;
    end
  end

endmodule

// File: rtl/lctp_ctrl.sv
module lctp_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [1:0]          kind,
  input  lctp_pkg::lctp_sts_t sts,
  output lctp_pkg::lctp_cmd_t cmd,
  output logic                busy,
  output logic                done
);
  import lctp_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_INIT  = 4'd1;
  localparam logic [3:0] S_LOAD  = 4'd2;
  localparam logic [3:0] S_COUNT = 4'd3;
  localparam logic [3:0] S_CHECK = 4'd4;
  localparam logic [3:0] S_DIV   = 4'd5;
  localparam logic [3:0] S_SEL   = 4'd6;
  localparam logic [3:0] S_GRAB  = 4'd7;
  localparam logic [3:0] S_DONE  = 4'd8;

  logic [3:0] state;
  logic [3:0] state_next;

  assign busy = (state != S_IDLE);
  assign done = (state == S_DONE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          unique case (kind)
            KIND_INIT: begin
              cmd.clear_used = 1'b1;
              state_next     = S_INIT;
            end
            KIND_LOAD: state_next = S_LOAD;
            KIND_PICK: state_next = S_COUNT;
            default:   state_next = S_DONE;
          endcase
        end
      end
      S_INIT: begin
        cmd.init_step = 1'b1;
        if (sts.def_last) begin
          state_next = S_DONE;
        end
      end
      S_LOAD: begin
        cmd.load_write = 1'b1;
        state_next     = S_DONE;
      end
      S_COUNT: begin
        cmd.count_step = 1'b1;
        if (sts.scan_last) begin
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.count_zero) begin
          cmd.set_none = 1'b1;
          state_next   = S_DONE;
        end else begin
          cmd.div_start = 1'b1;
          state_next    = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_next = S_SEL;
        end
      end
      S_SEL: begin
        cmd.sel_step = 1'b1;
        if (sts.hit) begin
          state_next = S_GRAB;
        end
      end
      S_GRAB: begin
        cmd.grab   = 1'b1;
        state_next = S_DONE;
      end
      S_DONE:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// File: rtl/lora_channel_table_picker_top.sv
// channel   | handshake         | payload
// ----------+-------------------+-----------------------------------
// item in   | start, busy       | item (kind, slot, value, random)
// result    | done (one cycle)  | result (frequency, none_available)
// config    | cfg_we            | cfg_index, cfg_data
//
// Init writes the DEFAULT_SLOTS default entries, load writes one entry, an unused kind only raises done.
// Pick: count scan over all TABLE_SLOTS slots, bit-serial modulo of the
// random value, select scan of up to TABLE_SLOTS slots, then fetch.
// Synchronous reset empties the table at once; no clearing pass.
// done lasts one cycle and the result cannot be held off.
module lora_channel_table_picker_top #(
  parameter int TABLE_SLOTS   = 16,
  parameter int DEFAULT_SLOTS = 3
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  lctp_pkg::item_t   item,
  output logic              done,
  output lctp_pkg::result_t result,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [30:0]       cfg_data
);
  import lctp_pkg::*;

  lctp_cmd_t cmd;
  lctp_sts_t sts;

  lctp_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .kind  (item.kind),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  lctp_dp #(
    .TABLE_SLOTS   (TABLE_SLOTS),
    .DEFAULT_SLOTS (DEFAULT_SLOTS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .item      (item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .sts       (sts),
    .result    (result)
  );

  a_done_pulse : assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("done held for more than one cycle");

  a_none_zero : assert property (@(posedge clk) disable iff (rst)
    (done && result.none_available) |-> (result.frequency == '0))
    else $error("empty pick returned a frequency");

  a_accept_busy : assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

endmodule

// File: sim/tb_lora_channel_table_picker_top.sv
module tb_lora_channel_table_picker_top;
  import lctp_pkg::*;

  localparam int TABLE_SLOTS   = 16;
  localparam int DEFAULT_SLOTS = 3;
  localparam int PICK_CYCLES   = 2 * TABLE_SLOTS + 37;
  localparam int STALL_LIMIT   = 2000;
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam logic [1:0] CFG_UNUSED  = 2'd3;
  localparam logic [30:0] FREQ_TOP   = 31'd1677721500;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  item_t       item_in = '0;
  logic        done;
  result_t     result_out;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = CFG_FREQ_A;
  logic [30:0] cfg_data = '0;

  logic [30:0] chan_table [TABLE_SLOTS];
  logic [30:0] dflt_freq [DEFAULT_SLOTS];
  result_t     pending_results [$];

  int mismatches = 0;
  int items_sent = 0;
  int results_checked = 0;
  int picks_seen = 0;
  int empty_picks = 0;
  int cfg_writes = 0;
  int stall_cycles = 0;

  lora_channel_table_picker_top #(
    .TABLE_SLOTS(TABLE_SLOTS),
    .DEFAULT_SLOTS(DEFAULT_SLOTS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .item(item_in),
    .done(done),
    .result(result_out),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic result_t predict_channel(item_t it);
    result_t r;
    int unsigned used;
    logic [31:0] n;
    logic [31:0] prod;
    int slot;
    r = '0;
    used = 0;
    case (it.kind)
      KIND_INIT: begin
        for (int i = 0; i < TABLE_SLOTS; i++)
          chan_table[i] = (i < DEFAULT_SLOTS) ? dflt_freq[i] : 31'd0;
      end
      KIND_LOAD: begin
        slot = DEFAULT_SLOTS + it.entry_slot;
        if (slot < JOIN_LIST_END && slot < TABLE_SLOTS) begin
          prod = 32'(it.entry_value) * 32'(FREQ_UNIT);
          r.frequency = prod[30:0];
          chan_table[slot] = prod[30:0];
        end
      end
      KIND_PICK: begin
        for (int i = 0; i < TABLE_SLOTS; i++)
          if (chan_table[i] != 0) used++;
        if (used == 0) begin
          r.none_available = 1'b1;
        end else begin
          n = it.random_value % used;
          for (int i = 0; i < TABLE_SLOTS; i++) begin
            if (chan_table[i] != 0) begin
              if (n == 0) begin
                r.frequency = chan_table[i];
                break;
              end
              n--;
            end
          end
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  always @(posedge clk) begin
    result_t want;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result freq %0d none %0b",
                                  result_out.frequency, result_out.none_available));
      end else begin
        want = pending_results.pop_front();
        if (result_out.frequency !== want.frequency)
          report_mismatch($sformatf("frequency %0d, wanted %0d",
                                    result_out.frequency, want.frequency));
        if (result_out.none_available !== want.none_available)
          report_mismatch($sformatf("none_available %0b, wanted %0b",
                                    result_out.none_available, want.none_available));
        results_checked++;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Timeout: no item accepted and no result for %0d cycles", STALL_LIMIT);
      $display("Regression FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic send_item(item_t it);
    start <= 1'b1;
    item_in <= it;
    do @(posedge clk); while (busy);
    pending_results.push_back(predict_channel(it));
    items_sent++;
    if (it.kind == KIND_PICK) picks_seen++;
  endtask

  task automatic send(logic [1:0] kind, logic [2:0] slot, logic [23:0] value,
                      logic [31:0] rnd);
    item_t it;
    it.kind = kind;
    it.entry_slot = slot;
    it.entry_value = value;
    it.random_value = rnd;
    send_item(it);
  endtask

  task automatic sender_gap(int pct);
    if (pct > 0 && $urandom_range(99) < pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 80)) @(posedge clk);
    end
  endtask

  // lets the block go idle before registers change or the run ends
  task automatic drain;
    start <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    @(posedge clk);
    repeat (PICK_CYCLES + 3) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [30:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    case (idx)
      CFG_FREQ_A: dflt_freq[0] = value;
      CFG_FREQ_B: dflt_freq[1] = value;
      CFG_FREQ_C: dflt_freq[2] = value;
      default: begin
      end
    endcase
    cfg_writes++;
  endtask

  task automatic set_defaults(logic [30:0] a, logic [30:0] b, logic [30:0] c);
    write_reg(CFG_FREQ_A, a);
    write_reg(CFG_FREQ_B, b);
    write_reg(CFG_FREQ_C, c);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [30:0] random_freq();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 20) return 31'd0;
    if (sel < 35) return FREQ_TOP;
    return 31'($urandom_range(0, 1677721500));
  endfunction

  function automatic item_t random_item();
    item_t it;
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 45)      it.kind = KIND_PICK;
    else if (sel < 80) it.kind = KIND_LOAD;
    else if (sel < 93) it.kind = KIND_INIT;
    else               it.kind = KIND_UNUSED;
    it.entry_slot = ($urandom_range(99) < 85) ? 3'($urandom_range(0, 4))
                                              : 3'($urandom_range(5, 7));
    sel = $urandom_range(99);
    if (sel < 12)      it.entry_value = '0;
    else if (sel < 20) it.entry_value = '1;
    else               it.entry_value = 24'($urandom);
    it.random_value = ($urandom_range(99) < 20) ? 32'($urandom_range(0, 20))
                                                : 32'($urandom);
    return it;
  endfunction

  task automatic test_empty_table;
    send(KIND_PICK, 3'd0, 24'd0, 32'd0);
    send(KIND_PICK, 3'd7, 24'hFFFFFF, 32'hFFFF_FFFF);
    send(KIND_UNUSED, 3'd2, 24'h123456, 32'h5A5A_A5A5);
    send(KIND_LOAD, 3'd7, 24'hFFFFFF, 32'd0);
    send(KIND_PICK, 3'd0, 24'd0, 32'd1);
  endtask

  task automatic test_defaults_pick;
    send(KIND_INIT, 3'd0, 24'd0, 32'd0);
    send(KIND_PICK, 3'd0, 24'd0, 32'd0);
    send(KIND_PICK, 3'd0, 24'd0, 32'd1);
    send(KIND_PICK, 3'd0, 24'd0, 32'd2);
    send(KIND_PICK, 3'd0, 24'd0, 32'hFFFF_FFFF);
  endtask

  task automatic test_join_list;
    send(KIND_LOAD, 3'd0, 24'hFFFFFF, 32'd0);
    send(KIND_LOAD, 3'd4, 24'd1, 32'd0);
    send(KIND_LOAD, 3'd1, 24'h800000, 32'hFFFF_FFFF);
    send(KIND_LOAD, 3'd5, 24'h0ABCDE, 32'd0);
    send(KIND_LOAD, 3'd1, 24'd0, 32'd0);
    send(KIND_PICK, 3'd0, 24'd0, 32'hFFFF_FFFF);
    send(KIND_PICK, 3'd0, 24'd0, 32'd3);
    send(KIND_PICK, 3'd0, 24'd0, 32'd4);
  endtask

  task automatic test_config_extremes;
    drain();
    set_defaults(31'd0, 31'd0, 31'd0);
    send(KIND_INIT, 3'd0, 24'd0, 32'd0);
    send(KIND_PICK, 3'd0, 24'd0, 32'd7);
    drain();
    set_defaults(FREQ_TOP, FREQ_TOP, FREQ_TOP);
    write_reg(CFG_UNUSED, 31'h7FFF_FFFF);
    cfg_we <= 1'b0;
    send(KIND_INIT, 3'd0, 24'd0, 32'd0);
    send(KIND_PICK, 3'd0, 24'd0, 32'd2);
  endtask

  task automatic test_random_traffic(int idle_pct, int count);
    drain();
    set_defaults(random_freq(), random_freq(), random_freq());
    for (int k = 0; k < count; k++) begin
      sender_gap(idle_pct);
      send_item(random_item());
    end
  endtask

  always @(posedge clk) begin
    if (!rst && done && result_out.none_available) empty_picks <= empty_picks + 1;
  end

  initial begin
    for (int i = 0; i < TABLE_SLOTS; i++) chan_table[i] = '0;
    dflt_freq[0] = 31'd868100000;
    dflt_freq[1] = 31'd868300000;
    dflt_freq[2] = 31'd868500000;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_table();
    test_defaults_pick();
    test_join_list();
    test_config_extremes();
    test_random_traffic(0, 300);
    test_random_traffic(72, 300);
    test_random_traffic(10, 300);
    drain();

    $display("Covered %0d items (%0d picks, %0d finding no channel), %0d results checked",
             items_sent, picks_seen, empty_picks, results_checked);
    $display("Register writes: %0d, sender pacing: none, heavy and light idling",
             cfg_writes);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
